### design/wwg_pkg.sv
// ----------------------------------------------------------------------------
// wwg_pkg
// Shared widths, cell codes, token and queue types for the wireworld stepper.
// ----------------------------------------------------------------------------
package wwg_pkg;

  // line buffer geometry
  localparam int MAX_ROW_CELLS = 32;
  localparam int COL_W         = (MAX_ROW_CELLS > 1) ? $clog2(MAX_ROW_CELLS) : 1;
  localparam int LEN_W         = $clog2(MAX_ROW_CELLS + 1);

  // row length register
  localparam int ROW_LEN_W = 6;
  localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = 6'd32;

  // cell codes
  localparam int CELL_W = 2;
  typedef logic [CELL_W-1:0] cell_t;
  localparam cell_t CELL_EMPTY = 2'd0;
  localparam cell_t CELL_HEAD  = 2'd1;
  localparam cell_t CELL_TAIL  = 2'd2;
  localparam cell_t CELL_COND  = 2'd3;

  // three columns of one window row, index 0 is the leftmost
  typedef logic [2:0][CELL_W-1:0] row3_t;

  typedef logic [COL_W-1:0] col_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [1:0]       rows_t;

  // output queue
  localparam int OQ_AW       = 3;
  localparam int OQ_DEPTH    = 1 << OQ_AW;
  localparam int OQ_CW       = OQ_AW + 1;
  localparam int OQ_SW       = OQ_CW + 1;
  localparam int OQ_ITEM_MAX = 2;

  typedef enum logic [1:0] {
    SEQ_STREAM,
    SEQ_PREV,
    SEQ_FINAL,
    SEQ_TAIL
  } seq_state_t;

  typedef enum logic [1:0] {
    TOK_NORMAL,
    TOK_PREV,
    TOK_FINAL,
    TOK_TAIL
  } tok_kind_t;

  // one column step issued to the window stage
  typedef struct packed {
    logic      valid;
    tok_kind_t kind;
    col_t      col;
    cell_t     v;
    rows_t     rr;
    logic      clear;
    logic      emit_mid;
    logic      emit_end;
    logic      last;
  } tok_t;

  typedef struct packed {
    logic  we;
    col_t  addr;
    cell_t old_d;
    cell_t rec_d;
  } ram_wr_t;

  typedef struct packed {
    cell_t next_state;
    logic  frame_done;
  } res_t;

  typedef struct packed {
    logic v0;
    logic v1;
    res_t d0;
    res_t d1;
  } push_t;

endpackage

### design/wwg_if.sv
// ----------------------------------------------------------------------------
// wwg channel interfaces
// Valid/ready channels for cells in, results out and the row length write.
// ----------------------------------------------------------------------------
interface wwg_cell_if;
  logic          valid;
  logic          ready;
  wwg_pkg::cell_t cell_state;
  logic          frame_end;

  modport source (output valid, output cell_state, output frame_end, input ready);
  modport sink   (input valid, input cell_state, input frame_end, output ready);
endinterface

interface wwg_result_if;
  logic          valid;
  logic          ready;
  wwg_pkg::cell_t next_state;
  logic          frame_done;

  modport source (output valid, output next_state, output frame_done, input ready);
  modport sink   (input valid, input next_state, input frame_done, output ready);
endinterface

interface wwg_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [wwg_pkg::ROW_LEN_W-1:0]    row_length;

  modport source (output valid, output row_length, input ready);
  modport sink   (input valid, input row_length, output ready);
endinterface

### design/wwg_ram.sv
// ----------------------------------------------------------------------------
// wwg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wwg_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### design/wwg_seq.sv
// ----------------------------------------------------------------------------
// wwg_seq
// Column and row counters, row length register and end-of-frame flush sequencer.
// ----------------------------------------------------------------------------
module wwg_seq (
  input  logic          clk,
  input  logic          rst_n,
  wwg_cell_if.sink      in_ch,
  wwg_cfg_if.sink       cfg_ch,
  input  logic          issue_ok,
  output wwg_pkg::tok_t tok
);

  logic [wwg_pkg::ROW_LEN_W-1:0] row_length_r;
  wwg_pkg::seq_state_t           st_r, st_nxt;
  wwg_pkg::col_t                 col_r, col_nxt;
  wwg_pkg::rows_t                rr_r, rr_nxt;
  wwg_pkg::col_t                 fcol_r, fcol_nxt;
  wwg_pkg::col_t                 fc_r, fc_nxt;
  wwg_pkg::rows_t                frr_r, frr_nxt;

  wwg_pkg::len_t                 len;
  wwg_pkg::col_t                 last_col;
  wwg_pkg::col_t                 c;
  logic                          in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  // clamp row length, clamp column
  always_comb begin
    if (row_length_r == '0) begin
      len = wwg_pkg::len_t'(1);
    end else if (row_length_r > wwg_pkg::ROW_LEN_W'(wwg_pkg::MAX_ROW_CELLS)) begin
      len = wwg_pkg::len_t'(wwg_pkg::MAX_ROW_CELLS);
    end else begin
      len = wwg_pkg::len_t'(row_length_r);
    end
    last_col = wwg_pkg::col_t'(len - wwg_pkg::len_t'(1));
    c = (wwg_pkg::len_t'(col_r) >= len) ? last_col : col_r;
  end

  always_comb begin
    st_nxt   = st_r;
    col_nxt  = col_r;
    rr_nxt   = rr_r;
    fcol_nxt = fcol_r;
    fc_nxt   = fc_r;
    frr_nxt  = frr_r;
    in_ready = 1'b0;
    tok      = '0;
    case (st_r)
      wwg_pkg::SEQ_STREAM: begin
        in_ready     = issue_ok;
        tok.valid    = in_ch.valid && issue_ok;
        tok.kind     = wwg_pkg::TOK_NORMAL;
        tok.col      = c;
        tok.v        = in_ch.cell_state;
        tok.rr       = rr_r;
        tok.clear    = (c == '0);
        tok.emit_mid = (rr_r != '0) && (c != '0);
        tok.emit_end = (rr_r != '0) && (c == last_col);
        if (tok.valid) begin
          if (in_ch.frame_end) begin
            fc_nxt  = c;
            frr_nxt = rr_r;
            col_nxt = '0;
            rr_nxt  = '0;
            if ((rr_r != '0) && (c != last_col)) begin
              st_nxt   = wwg_pkg::SEQ_PREV;
              fcol_nxt = wwg_pkg::col_t'(c + 1'b1);
            end else begin
              st_nxt   = wwg_pkg::SEQ_FINAL;
              fcol_nxt = '0;
            end
          end else if (c == last_col) begin
            col_nxt = '0;
            if (rr_r != 2'd2) begin
              rr_nxt = rr_r + 2'd1;
            end
          end else begin
            col_nxt = wwg_pkg::col_t'(c + 1'b1);
          end
        end
      end
      wwg_pkg::SEQ_PREV: begin
        // rest of the row above the final one, nothing below
        tok.valid    = issue_ok;
        tok.kind     = wwg_pkg::TOK_PREV;
        tok.col      = fcol_r;
        tok.rr       = frr_r;
        tok.emit_mid = 1'b1;
        tok.emit_end = (fcol_r == last_col);
        if (issue_ok) begin
          if (fcol_r == last_col) begin
            st_nxt   = wwg_pkg::SEQ_FINAL;
            fcol_nxt = '0;
          end else begin
            fcol_nxt = wwg_pkg::col_t'(fcol_r + 1'b1);
          end
        end
      end
      wwg_pkg::SEQ_FINAL: begin
        // final row replayed from the line buffers
        tok.valid    = issue_ok;
        tok.kind     = wwg_pkg::TOK_FINAL;
        tok.col      = fcol_r;
        tok.rr       = frr_r;
        tok.clear    = (fcol_r == '0);
        tok.emit_mid = (fcol_r != '0);
        tok.emit_end = (fcol_r == last_col);
        tok.last     = (fcol_r == fc_r) && (fc_r == last_col);
        if (issue_ok) begin
          if (fcol_r == fc_r) begin
            if (fc_r == last_col) begin
              st_nxt = wwg_pkg::SEQ_STREAM;
            end else begin
              st_nxt = wwg_pkg::SEQ_TAIL;
            end
          end else begin
            fcol_nxt = wwg_pkg::col_t'(fcol_r + 1'b1);
          end
        end
      end
      wwg_pkg::SEQ_TAIL: begin
        // column right of the short final row
        tok.valid    = issue_ok;
        tok.kind     = wwg_pkg::TOK_TAIL;
        tok.col      = wwg_pkg::col_t'(fc_r + 1'b1);
        tok.rr       = frr_r;
        tok.emit_mid = 1'b1;
        tok.last     = 1'b1;
        if (issue_ok) begin
          st_nxt = wwg_pkg::SEQ_STREAM;
        end
      end
      default: begin
        st_nxt = wwg_pkg::SEQ_STREAM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= wwg_pkg::ROW_LEN_RESET;
      st_r         <= wwg_pkg::SEQ_STREAM;
      col_r        <= '0;
      rr_r         <= '0;
      fcol_r       <= '0;
      fc_r         <= '0;
      frr_r        <= '0;
    end else begin
      if (cfg_ch.valid) begin
        row_length_r <= cfg_ch.row_length;
      end
      st_r   <= st_nxt;
      col_r  <= col_nxt;
      rr_r   <= rr_nxt;
      fcol_r <= fcol_nxt;
      fc_r   <= fc_nxt;
      frr_r  <= frr_nxt;
    end
  end

endmodule

### design/wwg_window.sv
// ----------------------------------------------------------------------------
// wwg_window
// Read-modify-write stage: forwarding, 3x3 window, cell rule and write-back.
// ----------------------------------------------------------------------------
module wwg_window (
  input  logic             clk,
  input  logic             rst_n,
  input  wwg_pkg::tok_t    tok,
  input  wwg_pkg::cell_t   old_rd,
  input  wwg_pkg::cell_t   rec_rd,
  output wwg_pkg::ram_wr_t wr,
  output wwg_pkg::push_t   push,
  output logic             s1_busy
);

  function automatic wwg_pkg::cell_t next_cell(input wwg_pkg::row3_t t,
                                               input wwg_pkg::row3_t m,
                                               input wwg_pkg::row3_t b);
    logic [3:0]     heads;
    wwg_pkg::cell_t res;
    heads = 4'd0;
    for (int k = 0; k < 3; k++) begin
      heads = heads + 4'(t[k] == wwg_pkg::CELL_HEAD) + 4'(b[k] == wwg_pkg::CELL_HEAD);
    end
    heads = heads + 4'(m[0] == wwg_pkg::CELL_HEAD) + 4'(m[2] == wwg_pkg::CELL_HEAD);
    case (m[1])
      wwg_pkg::CELL_HEAD: res = wwg_pkg::CELL_TAIL;
      wwg_pkg::CELL_TAIL: res = wwg_pkg::CELL_COND;
      wwg_pkg::CELL_COND: begin
        res = ((heads == 4'd1) || (heads == 4'd2)) ? wwg_pkg::CELL_HEAD : wwg_pkg::CELL_COND;
      end
      default: res = m[1];
    endcase
    return res;
  endfunction

  wwg_pkg::tok_t   tok_r;
  wwg_pkg::cell_t  win_lo_r [3];
  wwg_pkg::cell_t  win_hi_r [3];

  logic            lw_valid_r;
  wwg_pkg::col_t   lw_addr_r;
  wwg_pkg::cell_t  lw_old_r;
  wwg_pkg::cell_t  lw_rec_r;

  logic            hit;
  wwg_pkg::cell_t  old_q;
  wwg_pkg::cell_t  rec_q;
  wwg_pkg::cell_t  nv [3];
  wwg_pkg::row3_t  w [3];
  wwg_pkg::row3_t  e [3];
  wwg_pkg::cell_t  mid_v;
  wwg_pkg::cell_t  end_v;
  logic            both;

  assign s1_busy = tok_r.valid;

  always_comb begin
    // latest write wins over the ram's old data
    hit   = lw_valid_r && (lw_addr_r == tok_r.col);
    old_q = hit ? lw_old_r : old_rd;
    rec_q = hit ? lw_rec_r : rec_rd;

    nv[0] = wwg_pkg::CELL_EMPTY;
    nv[1] = wwg_pkg::CELL_EMPTY;
    nv[2] = wwg_pkg::CELL_EMPTY;
    case (tok_r.kind)
      wwg_pkg::TOK_NORMAL: begin
        nv[0] = (tok_r.rr >= 2'd2) ? old_q : wwg_pkg::CELL_EMPTY;
        nv[1] = (tok_r.rr != '0) ? rec_q : wwg_pkg::CELL_EMPTY;
        nv[2] = tok_r.v;
      end
      wwg_pkg::TOK_PREV: begin
        nv[0] = (tok_r.rr >= 2'd2) ? old_q : wwg_pkg::CELL_EMPTY;
        nv[1] = rec_q;
      end
      wwg_pkg::TOK_FINAL: begin
        nv[0] = old_q;
        nv[1] = rec_q;
      end
      wwg_pkg::TOK_TAIL: begin
        nv[0] = (tok_r.rr != '0) ? rec_q : wwg_pkg::CELL_EMPTY;
      end
      default: begin
        nv[0] = wwg_pkg::CELL_EMPTY;
      end
    endcase

    for (int r = 0; r < 3; r++) begin
      w[r][0] = tok_r.clear ? wwg_pkg::CELL_EMPTY : win_lo_r[r];
      w[r][1] = tok_r.clear ? wwg_pkg::CELL_EMPTY : win_hi_r[r];
      w[r][2] = nv[r];
      e[r][0] = w[r][1];
      e[r][1] = w[r][2];
      e[r][2] = wwg_pkg::CELL_EMPTY;
    end

    mid_v = next_cell(w[0], w[1], w[2]);
    end_v = next_cell(e[0], e[1], e[2]);
    both  = tok_r.emit_mid && tok_r.emit_end;

    push.v0            = tok_r.valid && (tok_r.emit_mid || tok_r.emit_end);
    push.d0.next_state = tok_r.emit_mid ? mid_v : end_v;
    push.d0.frame_done = tok_r.last && !both;
    push.v1            = tok_r.valid && both;
    push.d1.next_state = end_v;
    push.d1.frame_done = tok_r.last;

    wr.we    = tok_r.valid && (tok_r.kind == wwg_pkg::TOK_NORMAL);
    wr.addr  = tok_r.col;
    wr.old_d = nv[1];
    wr.rec_d = nv[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r      <= '0;
      lw_valid_r <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        win_lo_r[r] <= wwg_pkg::CELL_EMPTY;
        win_hi_r[r] <= wwg_pkg::CELL_EMPTY;
      end
    end else begin
      tok_r <= tok;
      if (tok_r.valid) begin
        for (int r = 0; r < 3; r++) begin
          win_lo_r[r] <= w[r][1];
          win_hi_r[r] <= w[r][2];
        end
      end
      if (wr.we) begin
        lw_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      lw_addr_r <= wr.addr;
      lw_old_r  <= wr.old_d;
      lw_rec_r  <= wr.rec_d;
    end
  end

endmodule

### design/wwg_out_fifo.sv
// ----------------------------------------------------------------------------
// wwg_out_fifo
// Result queue taking up to two items a cycle and giving one when the consumer is ready.
// ----------------------------------------------------------------------------
module wwg_out_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  wwg_pkg::push_t            push,
  wwg_result_if.source              out_ch,
  output logic [wwg_pkg::OQ_CW-1:0] count
);

  wwg_pkg::res_t             mem_r [wwg_pkg::OQ_DEPTH];
  logic [wwg_pkg::OQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [wwg_pkg::OQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [wwg_pkg::OQ_CW-1:0] count_r, count_nxt;
  logic [1:0]                n_push;
  logic                      pop;

  assign out_ch.valid      = (count_r != '0);
  assign out_ch.next_state = mem_r[rd_ptr_r].next_state;
  assign out_ch.frame_done = mem_r[rd_ptr_r].frame_done;
  assign count             = count_r;

  always_comb begin
    pop        = out_ch.valid && out_ch.ready;
    n_push     = {1'b0, push.v0} + {1'b0, push.v1};
    wr_ptr_nxt = wr_ptr_r + wwg_pkg::OQ_AW'(n_push);
    rd_ptr_nxt = rd_ptr_r + wwg_pkg::OQ_AW'(pop);
    count_nxt  = count_r + wwg_pkg::OQ_CW'(n_push) - wwg_pkg::OQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem_r[wr_ptr_r] <= push.d0;
    end
    if (push.v1) begin
      mem_r[wr_ptr_r + wwg_pkg::OQ_AW'(1)] <= push.d1;
    end
  end

endmodule

### design/wireworld_generation_step.sv
// ----------------------------------------------------------------------------
// wireworld_generation_step
// A cell's result is formed in the registered window stage from the item of the row below it, then queued.
// Throughput: 1 cell per cycle while the queue has room, bounded by the line buffer read-modify-write.
// At frame end input stalls while the buffered rows are flushed, longer if the queue fills.
// Reset: synchronous active low, clears counters, window and queue; line
// buffers keep old contents and get no clearing pass.
// ----------------------------------------------------------------------------
module wireworld_generation_step (
  input  logic         clk,
  input  logic         rst_n,
  wwg_cell_if.sink     in_ch,
  wwg_result_if.source out_ch,
  wwg_cfg_if.sink      cfg_ch
);

  // issue side: one column token a cycle while the queue has room, stream or flush
  wwg_pkg::tok_t              tok;
  logic                       issue_ok;

  // line buffer ports
  wwg_pkg::ram_wr_t           wr;
  wwg_pkg::cell_t             old_rd;
  wwg_pkg::cell_t             rec_rd;

  // window stage to queue
  wwg_pkg::push_t             push;
  logic                       s1_busy;
  logic [wwg_pkg::OQ_CW-1:0]  oq_count;
  logic [wwg_pkg::OQ_SW-1:0]  oq_demand;

  // a token may issue only if the queue can absorb the worst case of the
  // token already in the window stage plus this one, two results each
  always_comb begin
    oq_demand = wwg_pkg::OQ_SW'(oq_count)
              + (s1_busy ? wwg_pkg::OQ_SW'(wwg_pkg::OQ_ITEM_MAX) : '0);
    issue_ok  = (oq_demand <= wwg_pkg::OQ_SW'(wwg_pkg::OQ_DEPTH - wwg_pkg::OQ_ITEM_MAX));
  end

  // counters, row length register and the end-of-frame flush walk
  wwg_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .issue_ok (issue_ok),
    .tok      (tok)
  );

  // row two above the incoming cell
  wwg_ram #(
    .WIDTH (wwg_pkg::CELL_W),
    .DEPTH (wwg_pkg::MAX_ROW_CELLS)
  ) u_older_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.old_d),
    .raddr (tok.col),
    .rdata (old_rd)
  );

  // row directly above the incoming cell
  wwg_ram #(
    .WIDTH (wwg_pkg::CELL_W),
    .DEPTH (wwg_pkg::MAX_ROW_CELLS)
  ) u_recent_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.rec_d),
    .raddr (tok.col),
    .rdata (rec_rd)
  );

  // read data lands here in the cycle after issue; write-back in the same cycle
  wwg_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .tok     (tok),
    .old_rd  (old_rd),
    .rec_rd  (rec_rd),
    .wr      (wr),
    .push    (push),
    .s1_busy (s1_busy)
  );

  // end of row gives two results, start of row none: the queue evens it out
  wwg_out_fifo u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .out_ch (out_ch),
    .count  (oq_count)
  );

endmodule
